FILE: hdl/hdlcr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC-like receiver package
// Shared constants, word types and queue status for the frame receiver.
// ----------------------------------------------------------------------------
package hdlcr_pkg;

    localparam int MAX_FRAME_DEF = 1024;

    localparam int BYTE_W  = 8;
    localparam int EVENT_W = 3;
    localparam int INDEX_W = 10;
    localparam int SPACE_W = 16;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7e;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7d;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD = 3'd1;
    localparam logic [EVENT_W-1:0] EV_DONE    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SPACE   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DROP    = 3'd4;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_ERR,
        CMD_OPEN,
        CMD_CLOSE,
        CMD_DATA
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

endpackage
`default_nettype wire

FILE: hdl/hdlcr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC-like receiver front end
// Tracks flag and escape framing and turns each received byte into a word
// for the back end: open, close, data, error or nothing.
// ----------------------------------------------------------------------------
module hdlcr_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [hdlcr_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic                         i_link_error,
    output hdlcr_pkg::t_cmd                   o_cmd
);
    import hdlcr_pkg::*;

    localparam logic [1:0] ST_OUTSIDE = 2'd0;
    localparam logic [1:0] ST_INSIDE  = 2'd1;
    localparam logic [1:0] ST_ESCAPED = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_empty;
    logic       n_empty;
    t_cmd       cmd;

    always_comb begin
        n_state   = r_state;
        n_empty   = r_empty;
        cmd.kind  = CMD_NOP;
        cmd.data  = i_rx_byte;
        if (i_link_error) begin
            n_state  = ST_OUTSIDE;
            cmd.kind = CMD_ERR;
        end else begin
            unique case (r_state)
                ST_OUTSIDE: begin
                    if (i_rx_byte == FLAG_BYTE) begin
                        n_state  = ST_INSIDE;
                        n_empty  = 1'b1;
                        cmd.kind = CMD_OPEN;
                    end
                end
                ST_INSIDE: begin
                    if (i_rx_byte == FLAG_BYTE) begin
                        if (!r_empty) begin
                            n_state  = ST_OUTSIDE;
                            cmd.kind = CMD_CLOSE;
                        end
                    end else if (i_rx_byte == ESC_BYTE) begin
                        n_state = ST_ESCAPED;
                    end else begin
                        n_empty  = 1'b0;
                        cmd.kind = CMD_DATA;
                    end
                end
                ST_ESCAPED: begin
                    n_state  = ST_INSIDE;
                    n_empty  = 1'b0;
                    cmd.kind = CMD_DATA;
                    cmd.data = i_rx_byte ^ ESC_XOR;
                end
                default: begin
                    n_state = ST_OUTSIDE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_OUTSIDE;
            r_empty <= 1'b1;
        end else if (i_accept) begin
            r_state <= n_state;
            r_empty <= n_empty;
        end
    end

    assign o_cmd = cmd;

endmodule
`default_nettype wire

FILE: hdl/hdlcr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC-like receiver word queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module hdlcr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hdlcr_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output hdlcr_pkg::t_cmd     o_cmd,
    output hdlcr_pkg::t_queue_status o_status
);
    import hdlcr_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/hdlcr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC-like receiver back end
// Counts frame bytes, captures the protocol id and the control frame's
// buffer-space bytes, and registers one result word per queued word.
// ----------------------------------------------------------------------------
module hdlcr_back #(
    parameter int MAX_FRAME = hdlcr_pkg::MAX_FRAME_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cmd_valid,
    input  wire hdlcr_pkg::t_cmd               i_cmd,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [hdlcr_pkg::EVENT_W-1:0]      o_event_res,
    output logic [hdlcr_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [hdlcr_pkg::INDEX_W-1:0]      o_byte_index,
    output logic [hdlcr_pkg::INDEX_W-1:0]      o_payload_length,
    output logic [hdlcr_pkg::BYTE_W-1:0]       o_protocol_id,
    output logic [hdlcr_pkg::SPACE_W-1:0]      o_space_value
);
    import hdlcr_pkg::*;

    localparam int CNT_NEED = $clog2(MAX_FRAME + 2);
    localparam int CNT_W    = (CNT_NEED > INDEX_W) ? CNT_NEED : INDEX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [BYTE_W-1:0]  r_proto;
    logic [BYTE_W-1:0]  n_proto;
    logic [BYTE_W-1:0]  r_space_lo;
    logic [BYTE_W-1:0]  n_space_lo;
    logic [BYTE_W-1:0]  r_space_hi;
    logic [BYTE_W-1:0]  n_space_hi;
    logic [CNT_W-1:0]   cnt_m1;
    logic [EVENT_W-1:0] ev;
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    logic [INDEX_W-1:0] length;
    logic [SPACE_W-1:0] space;
    logic               r_out_valid;

    assign cnt_m1 = r_count - CNT_W'(1);
    assign o_pop  = i_cmd_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_count    = r_count;
        n_proto    = r_proto;
        n_space_lo = r_space_lo;
        n_space_hi = r_space_hi;
        ev         = EV_NONE;
        data       = '0;
        index      = '0;
        length     = '0;
        space      = '0;
        unique case (i_cmd.kind)
            CMD_ERR: begin
                n_count = '0;
            end
            CMD_OPEN: begin
                n_count    = '0;
                n_space_lo = '0;
                n_space_hi = '0;
            end
            CMD_CLOSE: begin
                if (r_proto == '0) begin
                    ev    = EV_SPACE;
                    space = {r_space_hi, r_space_lo};
                end else if (r_count > MAX_CNT) begin
                    ev = EV_DROP;
                end else begin
                    ev     = EV_DONE;
                    length = cnt_m1[INDEX_W-1:0];
                end
            end
            CMD_DATA: begin
                if (r_count < MAX_CNT) begin
                    if (r_count == '0) begin
                        n_proto = i_cmd.data;
                    end else if (r_proto == '0) begin
                        if (r_count == CNT_W'(1)) begin
                            n_space_lo = i_cmd.data;
                        end else if (r_count == CNT_W'(2)) begin
                            n_space_hi = i_cmd.data;
                        end
                    end else begin
                        ev    = EV_PAYLOAD;
                        data  = i_cmd.data;
                        index = cnt_m1[INDEX_W-1:0];
                    end
                end
                if (r_count <= MAX_CNT) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_proto     <= '0;
            r_space_lo  <= '0;
            r_space_hi  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count     <= n_count;
                r_proto     <= n_proto;
                r_space_lo  <= n_space_lo;
                r_space_hi  <= n_space_hi;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_event_res      <= ev;
            o_data_byte      <= data;
            o_byte_index     <= index;
            o_payload_length <= length;
            o_protocol_id    <= n_proto;
            o_space_value    <= space;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

FILE: hdl/hdlc_like_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HDLC-like frame receiver
// Flag and escape deframer for an asynchronous serial link.
// ----------------------------------------------------------------------------
// Takes one received byte per word and gives exactly one result word for each
// byte accepted, one byte per clock sustained while the output is not
// stalled. The front end classifies each accepted byte into a two-entry
// queue, and the back end updates the frame count and registers the result.
// Each side stalls on its own; the input stalls only when the queue is full.
// Frames longer than MAX_FRAME bytes are dropped, control frames (protocol
// id zero) report their buffer-space value instead.
module hdlc_like_frame_receiver #(
    parameter int MAX_FRAME = hdlcr_pkg::MAX_FRAME_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [hdlcr_pkg::BYTE_W-1:0]  i_rx_byte,
    input  wire logic                          i_link_error,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [hdlcr_pkg::EVENT_W-1:0]      o_event_res,
    output logic [hdlcr_pkg::BYTE_W-1:0]       o_data_byte,
    output logic [hdlcr_pkg::INDEX_W-1:0]      o_byte_index,
    output logic [hdlcr_pkg::INDEX_W-1:0]      o_payload_length,
    output logic [hdlcr_pkg::BYTE_W-1:0]       o_protocol_id,
    output logic [hdlcr_pkg::SPACE_W-1:0]      o_space_value
);
    import hdlcr_pkg::*;

    logic          in_accept;
    logic          pop;
    t_cmd          front_cmd;
    t_cmd          queue_cmd;
    t_queue_status q_status;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    hdlcr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_rx_byte    (i_rx_byte),
        .i_link_error (i_link_error),
        .o_cmd        (front_cmd)
    );

    hdlcr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    hdlcr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (q_status.valid),
        .i_cmd            (queue_cmd),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_data_byte      (o_data_byte),
        .o_byte_index     (o_byte_index),
        .o_payload_length (o_payload_length),
        .o_protocol_id    (o_protocol_id),
        .o_space_value    (o_space_value)
    );

    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.valid && !o_out_valid) |=> o_out_valid)
        else $error("queued word not delivered to the output register");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res == EV_PAYLOAD) |->
            (o_payload_length == '0 && o_space_value == '0))
        else $error("payload word carries frame-end fields");

    a_index_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_PAYLOAD) |->
            (o_byte_index == '0 && o_data_byte == '0))
        else $error("byte index or data set on a non-payload word");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res <= EV_DROP))
        else $error("undefined event code");

endmodule
`default_nettype wire
